// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

`endif

// File: src/kccb_pkg.sv
// shared constants and types of the keyed count coalescing buffer
`timescale 1ns / 1ps

package kccb_pkg;

  localparam int ENTRIES_DEFAULT = 10;

  localparam int PID_W     = 22;
  localparam int GRP_W     = 32;
  localparam int CNT_W     = 32;
  localparam int PAYLOAD_W = PID_W + GRP_W + CNT_W;
  localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

  typedef struct packed {
    logic                    last;
    logic signed [CNT_W-1:0] sum;
    logic [GRP_W-1:0]        grp;
    logic [PID_W-1:0]        pid;
  } out_item_t;

endpackage

// File: src/kccb_out_reg.sv
// output register stage of the result stream
`timescale 1ns / 1ps

module kccb_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  kccb_pkg::out_item_t           item,
  output logic                          free,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [kccb_pkg::TDATA_W-1:0]  m_tdata,
  output logic                          m_tlast
);

  // register is free when empty or when its transaction completes this cycle
  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= kccb_pkg::TDATA_W'({item.sum, item.grp, item.pid});
      m_tlast <= item.last;
    end
  end

endmodule

// File: src/keyed_count_coalescing_buffer.sv
// top level: keyed event count table with periodic in-order flush
`timescale 1ns / 1ps
// event path: the filled slots are read and their keys compared in order until a hit or the end;
//   events are taken one at a time, the next only after the scan and any flush end, set by the
//   single key read port and the one key comparator that scan the table a slot at a time
// flush: every ENTRIES-th event drains the filled slots one by one, waiting out any output stall
// reset: rst clears the sequencer, both counters and the output valid; table contents stay

module keyed_count_coalescing_buffer #(
  parameter int ENTRIES = kccb_pkg::ENTRIES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // input events
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [kccb_pkg::TDATA_W-1:0]  s_tdata,   // pid, group_id, count_add, zero pad
  // flushed entries
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [kccb_pkg::TDATA_W-1:0]  m_tdata,   // out_pid, out_group_id, total_count, zero pad
  output logic                          m_tlast    // last
);

  // counter width holds ENTRIES itself, index width addresses the slots
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  localparam int PID_W = kccb_pkg::PID_W;
  localparam int GRP_W = kccb_pkg::GRP_W;
  localparam int CNT_W = kccb_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,   // ready for the next event
    S_RD,     // issue a key read or finish the scan
    S_CMP,    // compare read key, accumulate on a hit
    S_FRD,    // flush: issue slot read
    S_FOUT    // flush: hand slot to the output register
  } state_t;

  state_t          state;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   entry_count;
  logic [CW-1:0]   event_counter;

  // event being processed
  logic [PID_W-1:0]        key;
  logic [GRP_W-1:0]        grp;
  logic signed [CNT_W-1:0] add;

  // slot table, one write and one read port each
  logic [PID_W-1:0]        key_mem [ENTRIES];
  logic [GRP_W-1:0]        grp_mem [ENTRIES];
  logic signed [CNT_W-1:0] sum_mem [ENTRIES];
  logic [PID_W-1:0]        rd_key;
  logic [GRP_W-1:0]        rd_grp;
  logic signed [CNT_W-1:0] rd_sum;
  logic [IW-1:0]           rd_addr;

  logic                    hit;
  logic                    scan_done;
  logic                    room;
  logic                    bump;
  logic                    flush_go;
  logic [CW-1:0]           event_next;
  logic                    mem_we;
  logic                    mem_new;
  logic [IW-1:0]           wr_addr;
  logic signed [CNT_W-1:0] sum_add;
  logic signed [CNT_W-1:0] sum_wd;

  logic                    out_load;
  logic                    out_free;
  kccb_pkg::out_item_t     out_item;

  assign s_tready = (state == S_IDLE);

  // the one key comparator and the one accumulator adder
  assign rd_addr   = idx[IW-1:0];
  assign hit       = (state == S_CMP) && (rd_key == key);
  assign scan_done = (state == S_RD) && (idx == entry_count);
  assign room      = (entry_count != FULL_CNT);
  assign sum_add   = rd_sum + add;

  // every event ends with either a hit or a finished scan
  assign bump       = hit || scan_done;
  assign event_next = event_counter + CW'(1);
  assign flush_go   = bump && (event_next == FULL_CNT);

  // a new key fills the next free slot while there is room, a hit rewrites its sum in place
  assign mem_we  = hit || (scan_done && room);
  assign mem_new = !hit;
  assign wr_addr = hit ? idx[IW-1:0] : entry_count[IW-1:0];
  assign sum_wd  = hit ? sum_add : add;

  always_ff @(posedge clk) begin
    rd_key <= key_mem[rd_addr];
    rd_grp <= grp_mem[rd_addr];
    rd_sum <= sum_mem[rd_addr];
    if (mem_we) begin
      sum_mem[wr_addr] <= sum_wd;
      if (mem_new) begin
        key_mem[wr_addr] <= key;
        grp_mem[wr_addr] <= grp;
      end
    end
  end

  // flush output: read data of slot idx, last one marked
  assign out_item.pid  = rd_key;
  assign out_item.grp  = rd_grp;
  assign out_item.sum  = rd_sum;
  assign out_item.last = ((idx + CW'(1)) == entry_count);
  assign out_load      = (state == S_FOUT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      entry_count   <= '0;
      event_counter <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            key   <= s_tdata[PID_W-1:0];
            grp   <= s_tdata[PID_W +: GRP_W];
            add   <= s_tdata[PID_W + GRP_W +: CNT_W];
            idx   <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          if (scan_done) begin
            // new key; with the table full the data is dropped
            if (room) begin
              entry_count <= entry_count + CW'(1);
            end
            state <= flush_go ? S_FRD : S_IDLE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            state <= flush_go ? S_FRD : S_IDLE;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_RD;
          end
        end
        S_FRD: begin
          state <= S_FOUT;
        end
        S_FOUT: begin
          if (out_free) begin
            if (out_item.last) begin
              entry_count <= '0;
              idx         <= '0;
              state       <= S_IDLE;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_FRD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // end of an event: count it and restart the index for scan or flush
      if (bump) begin
        event_counter <= flush_go ? '0 : event_next;
        idx           <= '0;
      end
    end
  end

  kccb_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .item     (out_item),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: src/kccb_checker.sv
// port-level checker for the keyed count coalescing buffer, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kccb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [kccb_pkg::TDATA_W-1:0]  s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [kccb_pkg::TDATA_W-1:0]  m_tdata,
  input logic                          m_tlast
);

  logic s_xfer;
  logic m_stall;

  assign s_xfer  = s_tvalid && s_tready;
  assign m_stall = m_tvalid && !m_tready;

  // a stalled result holds its payload
  `ASSERT_NEXT(a_m_hold, clk, rst, m_stall, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // one event at a time: ready drops right after a transaction
  `ASSERT_NEXT(a_one_event, clk, rst, s_xfer, !s_tready)

  // results only come out of a flush, never while the block sits ready
  `ASSERT_SAME(a_flush_only, clk, rst, $rose(m_tvalid), !$past(s_tready))

  // a waiting event keeps its payload until taken
  `ASSERT_NEXT(a_s_hold, clk, rst, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata))

endmodule

bind keyed_count_coalescing_buffer kccb_checker u_kccb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
